FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pce_pkg.sv
// Package for the nuclear repulsion energy and forces core.
// Holds sizes, the atom storage word and the force saturation function.
package pce_pkg;

  localparam int MAX_ATOMS = 32;
  localparam int IDX_W     = $clog2(MAX_ATOMS);
  localparam int CNT_W     = $clog2(MAX_ATOMS + 1);

  localparam int COORD_W = 32;
  localparam int CHG_W   = 7;
  localparam int OIDX_W  = 5;
  localparam int FRC_W   = 48;
  localparam int NRG_W   = 47;
  localparam int FACC_W  = 62;
  localparam int EACC_W  = 56;
  localparam int MUL_W   = 33;
  localparam int RAD_W   = 66;
  localparam int ROOT_W  = 33;
  localparam int DEN_W   = 35;
  localparam int NUM_W   = 64;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [CHG_W-1:0]          charge;
    logic                      quantum;
  } atom_t;

  // Scale the summed force by Z and clamp to the signed 48-bit range.
  function automatic logic [FRC_W-1:0] sat_force(input logic signed [FACC_W-1:0] s,
                                                 input logic [CHG_W-1:0] z);
    logic [FACC_W-1:0] m;
    logic [53:0]       p;
    logic              neg;
    logic [FRC_W-1:0]  res;
    neg = s[FACC_W-1];
    m   = neg ? FACC_W'(-s) : FACC_W'(s);
    p   = 54'(m[46:0]) * 54'(z);
    if (z == '0 || m == '0) begin
      res = '0;
    end else if (m[FACC_W-1:47] != '0) begin
      res = neg ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else if (neg) begin
      if (p > 54'(48'h8000_0000_0000)) p = 54'(48'h8000_0000_0000);
      res = FRC_W'(-p[FRC_W-1:0]);
    end else begin
      if (p > 54'(48'h7FFF_FFFF_FFFF)) p = 54'(48'h7FFF_FFFF_FFFF);
      res = p[FRC_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/pce_if.sv
// Handshake channel interfaces for the repulsion core: one for atoms in,
// one for per-atom results out. No dependencies.
interface pce_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [6:0]         nuclear_charge;
  logic               is_quantum;
  logic               last_atom;
  modport source(output valid, pos_x, pos_y, pos_z, nuclear_charge, is_quantum, last_atom,
                 input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, nuclear_charge, is_quantum, last_atom,
               output ready);
endinterface

interface pce_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         atom_index;
  logic signed [47:0] force_x;
  logic signed [47:0] force_y;
  logic signed [47:0] force_z;
  logic [46:0]        repulsion_energy;
  logic               coincident_error;
  logic               last_result;
  modport source(output valid, atom_index, force_x, force_y, force_z, repulsion_energy,
                 coincident_error, last_result, input ready);
  modport sink(input valid, atom_index, force_x, force_y, force_z, repulsion_energy,
               coincident_error, last_result, output ready);
endinterface

FILE: rtl/pce_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses pce_pkg for widths.
module pce_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [pce_pkg::NUM_W-1:0] num,
  input  logic [pce_pkg::DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [pce_pkg::NUM_W-1:0] quot
);
  import pce_pkg::*;

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [5:0]       cnt;
  logic [DEN_W:0]   rem_s;
  logic             ge;

  assign rem_s = {rem, num_sh[NUM_W-1]};
  assign ge    = rem_s >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '1;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      num_sh <= num;
      dvs    <= den;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem    <= ge ? DEN_W'(rem_s - {1'b0, dvs}) : rem_s[DEN_W-1:0];
      quot   <= {quot[NUM_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/pce_sqrt.sv
// Integer square root, two radicand bits per cycle.
// Uses pce_pkg for widths.
module pce_sqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [pce_pkg::RAD_W-1:0]  rad,
  output logic                   busy,
  output logic                   done,
  output logic [pce_pkg::ROOT_W-1:0] root
);
  import pce_pkg::*;

  logic [RAD_W-1:0] rad_sh;
  logic [33:0]      rem;
  logic [5:0]       cnt;
  logic [35:0]      rem_s;
  logic [35:0]      trial;
  logic             ge;

  // remainder never exceeds twice the root, so 34 bits carry it
  assign rem_s = {rem, rad_sh[RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 6'(RAD_W / 2 - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[RAD_W-3:0], 2'b00};
      rem    <= ge ? 34'(rem_s - trial) : rem_s[33:0];
      root   <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/pairwise_coulomb_energy_forces_core.sv
// Nuclear repulsion core: atoms are taken one word per cycle while idle and held in a
// small on-chip store (up to MAX_ATOMS; more are dropped). The word carrying last_atom
// starts the work: every non-quantum pair is handled in two passes, once per pair for the
// energy and once per ordered pair for the forces, on one shared square-root unit, one
// shared divider and one 33x33 multiplier. Each atom's result word leaves at the end of
// its force pass, one word per atom in load order. Input is not ready during this work.
// Depends on pce_pkg, pce_if, pce_sqrt, pce_div and assert_macros.svh.
`include "assert_macros.svh"

module pairwise_coulomb_energy_forces_core (
  input logic      clk,
  input logic      rst,
  pce_in_if.sink   in_ch,
  pce_out_if.source out_ch
);
  import pce_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_NEXT   = 5'd1;
  localparam logic [4:0] ST_CHK    = 5'd2;
  localparam logic [4:0] ST_SQ     = 5'd3;
  localparam logic [4:0] ST_SQ_END = 5'd4;
  localparam logic [4:0] ST_SQRT   = 5'd5;
  localparam logic [4:0] ST_DIVGO  = 5'd6;
  localparam logic [4:0] ST_E_DIV  = 5'd7;
  localparam logic [4:0] ST_F_DIV1 = 5'd8;
  localparam logic [4:0] ST_F_DIV2 = 5'd9;
  localparam logic [4:0] ST_F_UGO  = 5'd10;
  localparam logic [4:0] ST_F_U    = 5'd11;
  localparam logic [4:0] ST_F_M1   = 5'd12;
  localparam logic [4:0] ST_F_M2   = 5'd13;
  localparam logic [4:0] ST_INC    = 5'd14;
  localparam logic [4:0] ST_EMIT   = 5'd15;

  logic [4:0]       state;
  logic             phase;          // 0 energy pass, 1 force pass
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [1:0]       k;
  logic             coincident;

  atom_t mem [MAX_ATOMS];
  atom_t rd_a;
  atom_t rd_b;

  logic [MUL_W-1:0]        dmag [3];
  logic [2:0]              dneg;
  logic [RAD_W-1:0]        d2;
  logic [DEN_W-1:0]        r;
  logic [55:0]             a;
  logic [30:0]             u;
  logic [63:0]             p1;
  logic signed [FACC_W-1:0] facc [3];
  logic [EACC_W-1:0]       eacc;

  logic               ov;
  logic [OIDX_W-1:0]  o_idx;
  logic [FRC_W-1:0]   o_f [3];
  logic [NRG_W-1:0]   o_e;
  logic               o_coin;
  logic               o_last;

  logic             in_acc;
  logic             out_free;
  logic             emit_go;
  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [56:0]      term;
  logic             sq_start, sq_busy, sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic             div_start, div_busy, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic signed [COORD_W:0] diff [3];
  logic [COORD_W-1:0] ca [3];
  logic [COORD_W-1:0] cb [3];

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !ov || out_ch.ready;
  assign emit_go     = (state == ST_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (in_acc && count < CNT_W'(MAX_ATOMS)) begin
      mem[count[IDX_W-1:0]] <= '{x: in_ch.pos_x, y: in_ch.pos_y, z: in_ch.pos_z,
                                 charge: in_ch.nuclear_charge, quantum: in_ch.is_quantum};
    end
    rd_a <= mem[i[IDX_W-1:0]];
    rd_b <= mem[j[IDX_W-1:0]];
  end

  assign ca[0] = rd_a.x;
  assign ca[1] = rd_a.y;
  assign ca[2] = rd_a.z;
  assign cb[0] = rd_b.x;
  assign cb[1] = rd_b.y;
  assign cb[2] = rd_b.z;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      diff[n] = $signed({cb[n][COORD_W-1], cb[n]}) - $signed({ca[n][COORD_W-1], ca[n]});
    end
  end

  // shared multiplier
  always_comb begin
    case (state)
      ST_SQ: begin
        mul_a = dmag[k];
        mul_b = dmag[k];
      end
      ST_F_M1: begin
        mul_a = MUL_W'(a[31:0]);
        mul_b = MUL_W'(u);
      end
      ST_F_M2: begin
        mul_a = MUL_W'(a[55:32]);
        mul_b = MUL_W'(u);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign term  = 57'({mul_p[53:0], 2'b00}) + 57'(p1[63:30]);

  assign sq_start = (state == ST_SQ_END) && (d2 != '0);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    case (state)
      ST_DIVGO: begin
        div_start = 1'b1;
        div_num   = phase ? {15'b0, 1'b1, 48'b0}
                          : {18'b0, 14'(rd_a.charge) * 14'(rd_b.charge), 32'b0};
      end
      ST_F_DIV1: begin
        div_start = div_done;
        div_num   = div_quot;
      end
      ST_F_UGO: begin
        div_start = 1'b1;
        div_num   = {1'b0, dmag[k], 30'b0};
      end
      default: begin
        div_start = 1'b0;
        div_num   = '0;
      end
    endcase
  end

  pce_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (d2),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (sq_root)
  );

  pce_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (r),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= 1'b0;
      count      <= '0;
      i          <= '0;
      j          <= '0;
      k          <= '0;
      coincident <= 1'b0;
      ov         <= 1'b0;
    end else begin
      if (emit_go) ov <= 1'b1;
      else if (out_ch.ready) ov <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (count < CNT_W'(MAX_ATOMS)) count <= count + CNT_W'(1);
            if (in_ch.last_atom) begin
              state      <= ST_NEXT;
              phase      <= 1'b0;
              i          <= '0;
              j          <= '0;
              coincident <= 1'b0;
            end
          end
        end
        ST_NEXT: begin
          if (!phase) begin
            if (i >= count) begin
              phase <= 1'b1;
              i     <= '0;
              j     <= '0;
            end else if (j >= i) begin
              i <= i + CNT_W'(1);
              j <= '0;
            end else begin
              state <= ST_CHK;
            end
          end else begin
            if (j >= count) state <= ST_EMIT;
            else if (j == i) j <= j + CNT_W'(1);
            else state <= ST_CHK;
          end
        end
        ST_CHK: begin
          k     <= '0;
          state <= (rd_a.quantum || rd_b.quantum) ? ST_INC : ST_SQ;
        end
        ST_SQ: begin
          k <= k + 2'd1;
          if (k == 2'd2) state <= ST_SQ_END;
        end
        ST_SQ_END: begin
          if (d2 == '0) begin
            if (!phase) coincident <= 1'b1;
            state <= ST_INC;
          end else begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_done) state <= ST_DIVGO;
        end
        ST_DIVGO: begin
          state <= phase ? ST_F_DIV1 : ST_E_DIV;
        end
        ST_E_DIV: begin
          if (div_done) state <= ST_INC;
        end
        ST_F_DIV1: begin
          if (div_done) state <= ST_F_DIV2;
        end
        ST_F_DIV2: begin
          if (div_done) begin
            k     <= '0;
            state <= ST_F_UGO;
          end
        end
        ST_F_UGO: begin
          state <= ST_F_U;
        end
        ST_F_U: begin
          if (div_done) state <= ST_F_M1;
        end
        ST_F_M1: begin
          state <= ST_F_M2;
        end
        ST_F_M2: begin
          k     <= k + 2'd1;
          state <= (k == 2'd2) ? ST_INC : ST_F_UGO;
        end
        ST_INC: begin
          j     <= j + CNT_W'(1);
          state <= ST_NEXT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (i + CNT_W'(1) == count) begin
              state <= ST_IDLE;
              count <= '0;
            end else begin
              i     <= i + CNT_W'(1);
              j     <= '0;
              state <= ST_NEXT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      eacc <= '0;
      for (int n = 0; n < 3; n++) facc[n] <= '0;
    end else begin
      if (in_acc && in_ch.last_atom) eacc <= '0;
      if (state == ST_CHK) begin
        d2 <= '0;
        for (int n = 0; n < 3; n++) begin
          dneg[n] <= diff[n][COORD_W];
          dmag[n] <= diff[n][COORD_W] ? MUL_W'(-diff[n]) : MUL_W'(diff[n]);
        end
      end
      if (state == ST_SQ) d2 <= d2 + mul_p;
      if (state == ST_SQRT && sq_done) r <= DEN_W'(sq_root);
      if (state == ST_E_DIV && div_done) eacc <= eacc + EACC_W'(div_quot[46:0]);
      if (state == ST_F_DIV2 && div_done) a <= 56'(rd_b.charge) * 56'(div_quot[48:0]);
      if (state == ST_F_U && div_done) u <= div_quot[30:0];
      if (state == ST_F_M1) p1 <= mul_p[63:0];
      if (state == ST_F_M2) begin
        facc[k] <= dneg[k] ? facc[k] - $signed(FACC_W'(term))
                           : facc[k] + $signed(FACC_W'(term));
      end
      if (emit_go) begin
        for (int n = 0; n < 3; n++) facc[n] <= '0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (emit_go) begin
      o_idx  <= i[OIDX_W-1:0];
      for (int n = 0; n < 3; n++) begin
        o_f[n] <= rd_a.quantum ? '0 : sat_force(facc[n], rd_a.charge);
      end
      o_e    <= (eacc > EACC_W'({NRG_W{1'b1}})) ? {NRG_W{1'b1}} : eacc[NRG_W-1:0];
      o_coin <= coincident;
      o_last <= (i + CNT_W'(1) == count);
    end
  end

  assign out_ch.valid            = ov;
  assign out_ch.atom_index       = o_idx;
  assign out_ch.force_x          = o_f[0];
  assign out_ch.force_y          = o_f[1];
  assign out_ch.force_z          = o_f[2];
  assign out_ch.repulsion_energy = o_e;
  assign out_ch.coincident_error = o_coin;
  assign out_ch.last_result      = o_last;

  `ASSERT_IMP(a_div_nonzero, div_start, r != '0, "divider started with zero root")
  `ASSERT_IMP(a_emit_range, emit_go, i < count, "result for an atom not held")
  `ASSERT_NXT(a_units_idle, state == ST_IDLE, !sq_busy && !div_busy, "unit busy while idle")

endmodule

FILE: tb/tb_pairwise_coulomb_energy_forces_core.sv
// Testbench for the nuclear repulsion core: drives molecules atom by atom and checks
// every per-atom result word against a predictor kept in a small scoreboard class.
// Depends on pce_pkg, pce_if and the core itself.
module tb_pairwise_coulomb_energy_forces_core;
  import pce_pkg::*;

  localparam longint LIMIT = 5000000;

  typedef struct {
    logic [OIDX_W-1:0] idx;
    logic [FRC_W-1:0]  fx, fy, fz;
    logic [NRG_W-1:0]  nrg;
    logic              coinc;
    logic              lst;
  } atom_result_t;

  class energy_force_board;
    longint           px[MAX_ATOMS], py[MAX_ATOMS], pz[MAX_ATOMS];
    longint unsigned  zq[MAX_ATOMS];
    bit               qm[MAX_ATOMS];
    int unsigned      held;
    atom_result_t     awaited[$];
    int               errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    // floor(sqrt(dx^2+dy^2+dz^2)), exact at 128 bits
    function longint unsigned pair_root(int a, int b, output bit zero);
      logic [127:0]    s;
      longint unsigned d, r, t;
      s = '0;
      r = 0;
      d = mag(px[b] - px[a]); s = s + 128'(d) * 128'(d);
      d = mag(py[b] - py[a]); s = s + 128'(d) * 128'(d);
      d = mag(pz[b] - pz[a]); s = s + 128'(d) * 128'(d);
      zero = (s == '0);
      for (int bt = 34; bt >= 0; bt--) begin
        t = r | (64'd1 << bt);
        if (128'(t) * 128'(t) <= s) r = t;
      end
      return r;
    endfunction

    function logic [FRC_W-1:0] scale_force(longint s, longint unsigned z);
      longint unsigned m, p;
      m = mag(s);
      if (m > (64'd1 << 50)) m = 64'd1 << 50;
      p = m * z;
      if (s < 0) begin
        if (p > (64'd1 << 47)) p = 64'd1 << 47;
        return FRC_W'(-p);
      end
      if (p > 64'h7FFF_FFFF_FFFF) p = 64'h7FFF_FFFF_FFFF;
      return FRC_W'(p);
    endfunction

    function void note_atom(atom_t a, bit last);
      longint unsigned nrg_sum, r, inv, w, wh, wl, u, t;
      longint          acc[3], dd[3];
      bit              coinc, z;
      atom_result_t    res;
      if (held < MAX_ATOMS) begin
        px[held] = longint'(a.x);
        py[held] = longint'(a.y);
        pz[held] = longint'(a.z);
        zq[held] = a.charge;
        qm[held] = a.quantum;
        held++;
      end
      if (!last) return;
      coinc = 0;
      nrg_sum = 0;
      for (int i = 0; i < held; i++)
        for (int j = 0; j < i; j++) begin
          if (qm[i] || qm[j]) continue;
          r = pair_root(i, j, z);
          if (z) begin
            coinc = 1;
            continue;
          end
          nrg_sum += ((zq[i] * zq[j]) << 32) / r;
        end
      for (int i = 0; i < held; i++) begin
        acc[0] = 0; acc[1] = 0; acc[2] = 0;
        if (!qm[i])
          for (int j = 0; j < held; j++) begin
            if (j == i || qm[j]) continue;
            r = pair_root(i, j, z);
            if (z) continue;
            dd[0] = px[j] - px[i];
            dd[1] = py[j] - py[i];
            dd[2] = pz[j] - pz[i];
            inv = ((64'd1 << 48) / r) / r;
            w = zq[j] * inv;
            wh = w >> 32;
            wl = w & 64'hFFFF_FFFF;
            for (int k = 0; k < 3; k++) begin
              u = (mag(dd[k]) << 30) / r;
              t = ((wh * u) << 2) + ((wl * u) >> 30);
              acc[k] += dd[k] < 0 ? -longint'(t) : longint'(t);
            end
          end
        res.idx   = OIDX_W'(i);
        res.fx    = qm[i] ? '0 : scale_force(acc[0], zq[i]);
        res.fy    = qm[i] ? '0 : scale_force(acc[1], zq[i]);
        res.fz    = qm[i] ? '0 : scale_force(acc[2], zq[i]);
        res.nrg   = nrg_sum > 64'h7FFF_FFFF_FFFF ? {NRG_W{1'b1}} : NRG_W'(nrg_sum);
        res.coinc = coinc;
        res.lst   = (i + 1 == held);
        awaited = {awaited, res};
      end
      held = 0;
    endfunction

    function void mismatch(string f, logic [63:0] e, logic [63:0] g);
      errors++;
      $display("%0t %s expected %h actual %h", $time, f, e, g);
    endfunction

    function void check_result(atom_result_t got);
      atom_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t unexpected result word, index %0d", $time, got.idx);
        return;
      end
      e = awaited.pop_front();
      if (got.idx !== e.idx)     mismatch("atom_index", e.idx, got.idx);
      if (got.fx !== e.fx)       mismatch("force_x", e.fx, got.fx);
      if (got.fy !== e.fy)       mismatch("force_y", e.fy, got.fy);
      if (got.fz !== e.fz)       mismatch("force_z", e.fz, got.fz);
      if (got.nrg !== e.nrg)     mismatch("repulsion_energy", e.nrg, got.nrg);
      if (got.coinc !== e.coinc) mismatch("coincident_error", e.coinc, got.coinc);
      if (got.lst !== e.lst)     mismatch("last_result", e.lst, got.lst);
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  longint cycles = 0;
  int idle_mode = 0;   // 0 none, 1 sender 75, 2 receiver 75, 3 both 32, 4 long hold-off
  bit held_off = 0;
  int hold_cnt = 0;
  energy_force_board board;

  pce_in_if  in_ch();
  pce_out_if out_ch();

  pairwise_coulomb_energy_forces_core u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("pairwise_coulomb_energy_forces_core regression: fail");
      $finish;
    end
  end

  // monitors sample pre-edge values
  always @(posedge clk) begin
    atom_t a;
    atom_result_t r;
    if (!rst && in_ch.valid && in_ch.ready) begin
      a.x = in_ch.pos_x; a.y = in_ch.pos_y; a.z = in_ch.pos_z;
      a.charge = in_ch.nuclear_charge; a.quantum = in_ch.is_quantum;
      board.note_atom(a, in_ch.last_atom);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      r.idx = out_ch.atom_index; r.fx = out_ch.force_x; r.fy = out_ch.force_y;
      r.fz = out_ch.force_z; r.nrg = out_ch.repulsion_energy;
      r.coinc = out_ch.coincident_error; r.lst = out_ch.last_result;
      board.check_result(r);
    end
  end

  // receiver: random stalls, plus one long hold-off once results start coming
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_mode == 4 && !held_off && out_ch.valid) begin
      held_off <= 1;
      hold_cnt <= 4000;
      out_ch.ready <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ch.ready <= $urandom_range(0, 99) >= 75;
    end else if (idle_mode == 3) begin
      out_ch.ready <= $urandom_range(0, 99) >= 32;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [6:0] c, bit q, bit last);
    int pct;
    int gap;
    pct = (idle_mode == 1) ? 75 : (idle_mode == 3) ? 32 : 0;
    gap = 0;
    while ($urandom_range(0, 99) < pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    in_ch.pos_z <= z;
    in_ch.nuclear_charge <= c;
    in_ch.is_quantum <= q;
    in_ch.last_atom <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int style);
    case (style)
      0: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      1: return $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000;
      default: return $urandom;
    endcase
  endfunction

  // one molecule of n atoms; last_atom rides on the final word only
  task automatic send_molecule(int n, output int sent);
    logic [31:0] x, y, z;
    int style;
    style = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    x = 0; y = 0; z = 0;
    for (int i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(0, 9) != 0) begin
        x = rand_coord(style); y = rand_coord(style); z = rand_coord(style);
      end
      send_atom(x, y, z, $urandom_range(0, 127), $urandom_range(0, 4) == 0, i == n - 1);
    end
    sent = n;
  endtask

  // one edge first so the monitor has noted the last accepted word
  task automatic wait_drained();
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    int total;
    int sent;
    board = new();
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    in_ch.pos_z <= '0;
    in_ch.nuclear_charge <= '0;
    in_ch.is_quantum <= 1'b0;
    in_ch.last_atom <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single nucleus
    send_atom(32'h0001_0000, 32'hFFFF_0000, 32'h0, 7'd127, 0, 1);
    // two nuclei one Bohr apart
    send_atom(32'h0, 32'h0, 32'h0, 7'd1, 0, 0);
    send_atom(32'h0001_0000, 32'h0, 32'h0, 7'd1, 0, 1);
    // coincident pair among three
    send_atom(32'h0002_0000, 32'h0003_0000, 32'hFFFE_0000, 7'd8, 0, 0);
    send_atom(32'h0002_0000, 32'h0003_0000, 32'hFFFE_0000, 7'd6, 0, 0);
    send_atom(32'h0, 32'h0001_8000, 32'h0, 7'd1, 0, 1);
    // one quantum nucleus
    send_atom(32'h0, 32'h0, 32'h0, 7'd1, 1, 0);
    send_atom(32'h0000_C000, 32'h0, 32'h0, 7'd9, 0, 0);
    send_atom(32'h0, 32'h0002_0000, 32'h0, 7'd17, 0, 1);
    // opposite corners of the coordinate range
    send_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 7'd127, 0, 0);
    send_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd127, 0, 1);
    // tightly packed heavy nuclei: energy and forces saturate
    send_atom(32'h0, 32'h0, 32'h0, 7'd127, 0, 0);
    send_atom(32'h1, 32'h0, 32'h0, 7'd127, 0, 0);
    send_atom(32'h0, 32'h1, 32'h0, 7'd127, 0, 0);
    send_atom(32'h0, 32'h0, 32'hFFFF_FFFF, 7'd127, 0, 1);
    // zero charges
    send_atom(32'h0, 32'h0, 32'h0, 7'd0, 0, 0);
    send_atom(32'h0003_0000, 32'h0, 32'h0, 7'd0, 0, 1);
    // all quantum
    send_atom(32'h0, 32'h0, 32'h0, 7'd5, 1, 0);
    send_atom(32'h0001_0000, 32'h0, 32'h0, 7'd5, 1, 1);
    in_ch.valid <= 1'b0;
    wait_drained();

    total = 0;
    // more nuclei than the store holds; last_atom on a dropped word
    send_molecule(MAX_ATOMS + 2, sent);
    total += sent;
    for (int ph = 0; ph < 5; ph++) begin
      idle_mode = ph;
      for (int items = 0; items < 30; items += sent) begin
        send_molecule($urandom_range(0, 9) == 0 ? $urandom_range(7, 9) : $urandom_range(1, 5),
                      sent);
        total += sent;
      end
    end
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (500) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("pairwise_coulomb_energy_forces_core regression: pass");
    end else begin
      $display("pairwise_coulomb_energy_forces_core regression: fail");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/pce_pkg.sv
rtl/pce_if.sv
rtl/pce_div.sv
rtl/pce_sqrt.sv
rtl/pairwise_coulomb_energy_forces_core.sv
tb/tb_pairwise_coulomb_energy_forces_core.sv
